// ===== hw/rtl/upd_pkg.sv =====
// Package for the URL percent decoder: item types, character constants,
// escape phase and status codes, and the hex digit and sanitizing helpers.
// Depends on nothing; every other file of the block imports it.
package upd_pkg;

    // One encoded input byte and its end-of-string flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // One result item for each input item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       end_of_string;
        logic [1:0] escape_status;
    } t_out_item;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] SUB_CHAR   = 8'h5F;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;
    localparam logic [7:0] DEL_CHAR   = 8'd127;

    // Escape phase codes.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    // Escape status codes.
    localparam logic [1:0] ST_PLAIN     = 2'd0;
    localparam logic [1:0] ST_DECODED   = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // Returns {valid, value}; the value is zero when the byte is no hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // Control characters and DEL are replaced by an underscore.
    function automatic logic [7:0] sanitize(input logic [7:0] b);
        if (b < CTRL_LIMIT || b == DEL_CHAR) begin
            return SUB_CHAR;
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/url_percent_decoder_unit.sv =====
// Top level of the URL percent decoder: input register, decode core and
// result register. Depends on upd_pkg and upd_decode_core.
//
// Usage. Encoded bytes enter on the input channel (i_in_valid, o_in_ready,
// i_in_item), one item per byte, with in_last set on the final byte of a
// string. Every input item gives exactly one result item on the output
// channel (o_out_valid, i_out_ready, o_out_item). A result carries the
// decoded byte with byte_present, the end-of-string flag and the escape
// status; steps that emit nothing carry out_byte zero.
// Path: an accepted item is held in the input register, then decoded by
// the core and stored in the result register, from which it is shown.
// Throughput is one item per cycle while the receiver does not stall, set
// by the escape phase register in the core.
// Reset clears both stage valid bits and returns the escape state to
// outside an escape. When the receiver stalls, the result register holds
// its item, the input register fills, and o_in_ready drops only when both
// stages hold items; it rises again in the cycle the result is taken.
module url_percent_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  upd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output upd_pkg::t_out_item o_out_item
);
    import upd_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item result;
    logic      out_free;
    logic      advance;

    // The result register can take a new item if it is empty or is being
    // drained this cycle; the stored input item then moves forward.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    upd_decode_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== hw/rtl/upd_decode_core.sv =====
// Escape state machine and byte decode of the URL percent decoder.
// Depends on upd_pkg for the item types, codes and helper functions.
module upd_decode_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  upd_pkg::t_in_item  i_item,
    output upd_pkg::t_out_item o_result
);
    import upd_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_high_nibble, n_high_nibble;
    logic       r_high_ok, n_high_ok;
    logic [4:0] digit;

    assign digit = hex_digit(i_item.in_byte);

    always_comb begin
        n_phase       = r_phase;
        n_high_nibble = r_high_nibble;
        n_high_ok     = r_high_ok;
        o_result               = '0;
        o_result.end_of_string = i_item.in_last;
        unique case (r_phase)
            PH_PCT: begin
                n_high_nibble = digit[3:0];
                n_high_ok     = digit[4];
                n_phase       = PH_DIGIT;
                if (i_item.in_last) begin
                    o_result.escape_status = ST_TRUNCATED;
                end
            end
            PH_DIGIT: begin
                if (digit[4] && r_high_ok) begin
                    o_result.out_byte      = sanitize({r_high_nibble, digit[3:0]});
                    o_result.byte_present  = 1'b1;
                    o_result.escape_status = ST_DECODED;
                end else begin
                    o_result.escape_status = ST_INVALID;
                end
                n_phase = PH_IDLE;
            end
            default: begin
                // The unused phase code behaves as outside an escape.
                if (i_item.in_byte == PCT_CHAR) begin
                    n_phase = PH_PCT;
                    if (i_item.in_last) begin
                        o_result.escape_status = ST_TRUNCATED;
                    end
                end else begin
                    o_result.out_byte     = sanitize(i_item.in_byte);
                    o_result.byte_present = 1'b1;
                    n_phase               = PH_IDLE;
                end
            end
        endcase
        if (i_item.in_last) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_high_nibble <= 4'd0;
            r_high_ok     <= 1'b0;
        end else if (i_advance) begin
            r_phase       <= n_phase;
            r_high_nibble <= n_high_nibble;
            r_high_ok     <= n_high_ok;
        end
    end

endmodule

// ===== hw/rtl/upd_checker.sv =====
// Port-level checks on the URL percent decoder results, bound to the top.
// Depends on upd_pkg for the result type and status codes.
module upd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input upd_pkg::t_out_item o_out_item
);
    import upd_pkg::*;

    // A result that emits nothing carries a zero byte.
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.byte_present) |-> (o_out_item.out_byte == 8'd0))
        else $error("absent byte is not zero");

    // Emitted bytes are never control characters or DEL.
    a_sanitized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.byte_present)
            |-> (o_out_item.out_byte >= CTRL_LIMIT && o_out_item.out_byte != DEL_CHAR))
        else $error("unsanitized byte emitted");

    // A decoded escape emits a byte, a dropped escape emits none.
    a_status_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.escape_status == ST_DECODED)
            == o_out_item.byte_present
            || o_out_item.escape_status == ST_PLAIN))
        else $error("escape status disagrees with byte_present");

    // A stalled result stays offered with the same contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_item (o_out_item)
);

// ===== bench/upd_result_checker.sv =====
// Result checker for the URL percent decoder: watches both channels, predicts
// every result from the accepted input items and compares field by field.
// Depends on upd_pkg for the item types, character constants and status codes.
module upd_result_checker
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_error_count,
    output int        o_pending_count,
    output int        o_checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Escape tracking state of the predictor.
    logic [1:0] esc_phase = PH_IDLE;
    logic [3:0] hi_nib    = 4'd0;
    logic       hi_ok     = 1'b0;

    t_out_item  decode_queue[$];
    int         errors  = 0;
    int         pending = 0;
    int         checked = 0;

    assign o_error_count   = errors;
    assign o_pending_count = pending;
    assign o_checked_count = checked;

    function automatic logic is_hex(input logic [7:0] c, output logic [3:0] v);
        logic [7:0] off;
        off    = 8'd0;
        is_hex = 1'b1;
        if (c >= 8'h30 && c <= 8'h39) begin
            off = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            off = c - 8'h41 + 8'd10;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            off = c - 8'h61 + 8'd10;
        end else begin
            is_hex = 1'b0;
        end
        v = off[3:0];
    endfunction

    function automatic logic [7:0] scrub(input logic [7:0] b);
        return (b < CTRL_LIMIT || b == DEL_CHAR) ? SUB_CHAR : b;
    endfunction

    // Works out the result of one byte and moves the escape state on.
    task automatic advance_decoder(input t_in_item it, output t_out_item res);
        logic [3:0] nib;
        logic       ok;
        res               = '0;
        res.end_of_string = it.in_last;
        res.escape_status = ST_PLAIN;
        ok = is_hex(it.in_byte, nib);
        case (esc_phase)
            PH_PCT: begin
                hi_nib    = nib;
                hi_ok     = ok;
                esc_phase = PH_DIGIT;
                if (it.in_last) begin
                    res.escape_status = ST_TRUNCATED;
                end
            end
            PH_DIGIT: begin
                if (ok && hi_ok) begin
                    res.out_byte      = scrub({hi_nib, nib});
                    res.byte_present  = 1'b1;
                    res.escape_status = ST_DECODED;
                end else begin
                    res.escape_status = ST_INVALID;
                end
                esc_phase = PH_IDLE;
            end
            default: begin
                if (it.in_byte == PCT_CHAR) begin
                    esc_phase = PH_PCT;
                    if (it.in_last) begin
                        res.escape_status = ST_TRUNCATED;
                    end
                end else begin
                    res.out_byte     = scrub(it.in_byte);
                    res.byte_present = 1'b1;
                    esc_phase        = PH_IDLE;
                end
            end
        endcase
        if (it.in_last) begin
            esc_phase = PH_IDLE;
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            esc_phase = PH_IDLE;
            hi_nib    = 4'd0;
            hi_ok     = 1'b0;
            decode_queue.delete();
        end else begin
            // Results leave before new items enter, so the oldest comes first.
            if (i_out_valid && i_out_ready) begin
                if (decode_queue.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                             $time, i_out_item);
                end else begin
                    want = decode_queue.pop_front();
                    report_field("out_byte", int'(want.out_byte),
                                 int'(i_out_item.out_byte));
                    report_field("byte_present", int'(want.byte_present),
                                 int'(i_out_item.byte_present));
                    report_field("end_of_string", int'(want.end_of_string),
                                 int'(i_out_item.end_of_string));
                    report_field("escape_status", int'(want.escape_status),
                                 int'(i_out_item.escape_status));
                    checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_decoder(i_in_item, want);
                decode_queue.push_back(want);
            end
        end
        pending = decode_queue.size();
    end

endmodule

// ===== bench/url_percent_decoder_unit_tb.sv =====
// Testbench top for the URL percent decoder: clock, reset, byte stimulus,
// receiver stalls and the final verdict.
// Depends on upd_pkg, url_percent_decoder_unit and upd_result_checker.
module url_percent_decoder_unit_tb
    import upd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 600;
    localparam int WAIT_MAX    = 17;
    // The slowest correct run is bounded by the sender gap, the receiver stall
    // and the two register stages for each item, so this leaves a wide
    // margin over at most 615 items.
    localparam int CYCLE_LIMIT = 200000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    int errors;
    int pending;
    int checked;
    int cycles       = 0;
    int bytes_sent   = 0;
    int strings_sent = 0;

    // While this is set, both sides run without idle cycles.
    bit calm = 1'b0;
    bit drained = 1'b0;

    url_percent_decoder_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    upd_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_in_item       (in_item),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_item      (out_item),
        .o_error_count   (errors),
        .o_pending_count (pending),
        .o_checked_count (checked)
    );

    initial begin
        forever begin
            #6 clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, WAIT_MAX));
    endfunction

    // Sends one byte. It is entered right after a rising edge and returns at
    // the edge where the item was taken, with valid still high, so the next
    // call can keep valid up and change only the payload. Handshake outputs
    // are sampled at the falling edge, where they have settled, and the
    // transfer itself happens at the rising edge that follows.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int   gap;
        logic taken;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{in_byte: b, in_last: last};
        do begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
        bytes_sent++;
        if (last) begin
            strings_sent++;
        end
    endtask

    // Stops sending and waits until every accepted item has its result.
    task automatic drain();
        in_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (pending != 0);
        @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10) begin
            return 8'h30 + v;
        end
        return (upper ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    // A byte that is not a hex digit, from every gap around the digit ranges,
    // the percent sign and the zero byte included.
    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(8'h00, 8'h2F));
            1:       return 8'($urandom_range(8'h3A, 8'h40));
            2:       return 8'($urandom_range(8'h47, 8'h60));
            3:       return 8'($urandom_range(8'h67, 8'hFF));
            default: return PCT_CHAR;
        endcase
    endfunction

    // A byte that does not open an escape, mostly printable text.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 7) begin
            c = 8'($urandom_range(32, 126));
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        if (c == PCT_CHAR) begin
            c = 8'h2B;
        end
        return c;
    endfunction

    // Builds one string. Most of it is plain text and well-formed escapes with
    // random digits in either case; the rest is broken escapes, raw noise and,
    // now and then, an escape cut off by the end of the string.
    task automatic send_random_string();
        logic [7:0] text[$];
        int         len;
        int         pick;
        len = $urandom_range(1, 12);
        while (text.size() < len) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                text.push_back(plain_char());
            end else if (pick < 85) begin
                text.push_back(PCT_CHAR);
                text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            end else if (pick < 95) begin
                text.push_back(PCT_CHAR);
                if ($urandom_range(0, 1) == 0) begin
                    text.push_back(non_hex_char());
                    text.push_back(hex_char(4'($urandom_range(0, 15)),
                                            1'($urandom_range(0, 1))));
                end else begin
                    text.push_back(hex_char(4'($urandom_range(0, 15)),
                                            1'($urandom_range(0, 1))));
                    text.push_back(non_hex_char());
                end
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            text.push_back(PCT_CHAR);
            if ($urandom_range(0, 1) == 0) begin
                text.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            end
        end
        foreach (text[k]) begin
            send_byte(text[k], k == text.size() - 1);
        end
    endtask

    // Receiver: for every result it draws a stall, holds ready low that long,
    // then keeps ready high until a result has been taken.
    initial begin : receiver
        int   stall;
        logic taken;
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do begin
                @(negedge clk);
                taken = out_valid;
                @(posedge clk);
            end while (!taken);
        end
    end

    initial begin : stimulus
        // Synchronous reset held low from the start, then released once.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Byte extremes outside any escape: a low control byte, top byte,
        // DEL, the zero byte and the first printable byte.
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h20, 1'b1);
        // A mixed-case escape, an escape that decodes to a control byte,
        // a bad first digit, a percent sign where a digit belongs and a zero
        // byte as a digit.
        send_byte(PCT_CHAR, 1'b0);
        send_byte("a", 1'b0);
        send_byte("F", 1'b0);
        send_byte(PCT_CHAR, 1'b0);
        send_byte("0", 1'b0);
        send_byte("9", 1'b0);
        send_byte(PCT_CHAR, 1'b0);
        send_byte("G", 1'b0);
        send_byte("1", 1'b0);
        send_byte(PCT_CHAR, 1'b0);
        send_byte(PCT_CHAR, 1'b0);
        send_byte("4", 1'b0);
        send_byte(PCT_CHAR, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte("5", 1'b1);
        // Strings that end on the percent sign, on the first digit, and a
        // one-byte plain string right after them.
        send_byte(PCT_CHAR, 1'b1);
        send_byte(PCT_CHAR, 1'b0);
        send_byte("9", 1'b1);
        send_byte("x", 1'b1);

        while (bytes_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 4) == 0);
            // Halfway through, let the pipeline run completely dry once.
            if (!drained && bytes_sent >= ITEM_TARGET / 2) begin
                drain();
                drained = 1'b1;
            end
            send_random_string();
        end

        drain();
        repeat (8) @(posedge clk);

        $display("summary: %0d bytes in %0d strings sent, %0d results compared",
                 bytes_sent, strings_sent, checked);
        $display("summary: plain, control and high bytes, decoded, invalid and cut-off escapes");
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/upd_pkg.sv
hw/rtl/upd_decode_core.sv
hw/rtl/url_percent_decoder_unit.sv
hw/rtl/upd_checker.sv
bench/upd_result_checker.sv
bench/url_percent_decoder_unit_tb.sv
